@@ hdl/utf8v_pkg.sv @@
package utf8v_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 21;
	localparam int unsigned CntW  = 2;

	// Code point bounds
	localparam logic [CpW-1:0] CpTab        = 21'h00009;
	localparam logic [CpW-1:0] CpLf         = 21'h0000A;
	localparam logic [CpW-1:0] CpCr         = 21'h0000D;
	localparam logic [CpW-1:0] CpCtrlEnd    = 21'h00020;
	localparam logic [CpW-1:0] CpC1Lo       = 21'h0007F;
	localparam logic [CpW-1:0] CpC1Hi       = 21'h0009F;
	localparam logic [CpW-1:0] CpMin3       = 21'h00800;
	localparam logic [CpW-1:0] CpMin4       = 21'h10000;
	localparam logic [CpW-1:0] CpSurLo      = 21'h0D800;
	localparam logic [CpW-1:0] CpSurHi      = 21'h0DFFF;
	localparam logic [CpW-1:0] CpNcMask     = 21'h0FFFE;
	localparam logic [CpW-1:0] CpNcLo       = 21'h0FDD0;
	localparam logic [CpW-1:0] CpNcHi       = 21'h0FDEF;
	localparam logic [CpW-1:0] CpPlaneLimit = 21'hF0000;
	localparam logic [CpW-1:0] CpZwLo       = 21'h0200B;
	localparam logic [CpW-1:0] CpZwHi       = 21'h0200F;
	localparam logic [CpW-1:0] CpBidiLo     = 21'h0202A;
	localparam logic [CpW-1:0] CpBidiHi     = 21'h0202E;

	// Continuation counts of multi-byte sequences
	localparam logic [CntW-1:0] ContNone  = 2'd0;
	localparam logic [CntW-1:0] ContOne   = 2'd1;
	localparam logic [CntW-1:0] ContTwo   = 2'd2;
	localparam logic [CntW-1:0] ContThree = 2'd3;

	typedef struct packed {
		logic [CntW-1:0] pend;
		logic [CntW-1:0] seqlen;
		logic [CpW-1:0]  acc;
		logic            err;
	} utf8v_state_t;

	localparam utf8v_state_t StateIdle = '{pend: ContNone, seqlen: ContNone,
		acc: '0, err: 1'b0};

endpackage

@@ hdl/utf8v_cpcheck.sv @@
module utf8v_cpcheck
	import utf8v_pkg::*;
(
	input  logic [CpW-1:0]  cp,
	input  logic [CntW-1:0] conts,
	output logic            ok
);

	always_comb begin
		priority if (conts == ContTwo && cp < CpMin3) begin
			ok = 1'b0;
		end else if (conts == ContThree && cp < CpMin4) begin
			ok = 1'b0;
		end else if (cp == CpTab || cp == CpLf || cp == CpCr) begin
			ok = 1'b1;
		end else if (cp < CpCtrlEnd || (cp >= CpC1Lo && cp <= CpC1Hi)) begin
			ok = 1'b0;
		end else if (cp >= CpSurLo && cp <= CpSurHi) begin
			ok = 1'b0;
		end else if ((cp & CpNcMask) == CpNcMask) begin
			ok = 1'b0;
		end else if (cp >= CpNcLo && cp <= CpNcHi) begin
			ok = 1'b0;
		end else if (cp >= CpPlaneLimit) begin
			ok = 1'b0;
		end else if (cp >= CpZwLo && cp <= CpZwHi) begin
			ok = 1'b0;
		end else if (cp >= CpBidiLo && cp <= CpBidiHi) begin
			ok = 1'b0;
		end else begin
			ok = 1'b1;
		end
	end

endmodule

@@ hdl/utf8v_step.sv @@
module utf8v_step
	import utf8v_pkg::*;
(
	input  utf8v_state_t     cur,
	input  logic [ByteW-1:0] b,
	output utf8v_state_t     nxt,
	output logic             verdict
);

	logic [CpW-1:0]  acc_shift;
	logic [CntW-1:0] pend_dec;
	logic [CpW-1:0]  chk_cp;
	logic [CntW-1:0] chk_conts;
	logic            chk_ok;

	assign acc_shift = {cur.acc[CpW-7:0], b[5:0]};
	assign pend_dec  = cur.pend - ContOne;

	// Check the completed code point: the assembled value mid-sequence, else the ASCII byte.
	assign chk_cp    = (cur.pend != ContNone) ? acc_shift : {{(CpW-ByteW){1'b0}}, b};
	assign chk_conts = (cur.pend != ContNone) ? cur.seqlen : ContNone;

	utf8v_cpcheck u_cpcheck (
		.cp    (chk_cp),
		.conts (chk_conts),
		.ok    (chk_ok)
	);

	always_comb begin
		nxt = cur;
		priority if (cur.pend != ContNone) begin
			if (b[7:6] != 2'b10) begin
				// drop the broken sequence
				nxt     = StateIdle;
				nxt.err = 1'b1;
			end else begin
				nxt.acc  = acc_shift;
				nxt.pend = pend_dec;
				if (pend_dec == ContNone) begin
					nxt.err    = cur.err | ~chk_ok;
					nxt.seqlen = ContNone;
					nxt.acc    = '0;
				end
			end
		end else if (!b[7]) begin
			nxt.err = cur.err | ~chk_ok;
		end else if (b[7:1] == 7'b1100000) begin
			nxt.err = 1'b1;
		end else if (b[7:5] == 3'b110) begin
			nxt.pend   = ContOne;
			nxt.seqlen = ContOne;
			nxt.acc    = {{(CpW-5){1'b0}}, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			nxt.pend   = ContTwo;
			nxt.seqlen = ContTwo;
			nxt.acc    = {{(CpW-4){1'b0}}, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			nxt.pend   = ContThree;
			nxt.seqlen = ContThree;
			nxt.acc    = {{(CpW-3){1'b0}}, b[2:0]};
		end else begin
			nxt.err = 1'b1;
		end
	end

	assign verdict = ~nxt.err & (nxt.pend == ContNone);

endmodule

@@ hdl/utf8_text_validator.sv @@
// Streaming UTF-8 text checker. Feed a string one byte per request on the input
// channel and mark its final byte with last_byte; exactly one result request
// follows per string, with text_valid high when every code point decoded cleanly
// and passed the text rules (no overlong forms, no controls other than tab, line
// feed and carriage return, no C1, surrogates, noncharacters, U+F0000 and above,
// or the listed zero-width and bidi marks) and no sequence was left truncated.
// Bytes without last_byte produce nothing. Throughput is one byte per clock
// unless a last byte waits as below: the decode step is combinational between
// the input register and the state and result registers. An accepted last byte
// goes first to the input register, then to the result register. A last byte
// waits in the input register only while the result register holds a result that
// has not been taken; other bytes never wait. After each last byte the decoder
// returns to its idle state for the next string.
module utf8_text_validator
	import utf8v_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ByteW-1:0] data_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             text_valid
);

	// Input register stage
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;

	// Decoder state and result register
	utf8v_state_t state_q;
	utf8v_state_t state_nxt;
	logic         verdict;
	logic         out_valid_q;
	logic         text_valid_q;

	logic out_free;
	logic adv_s1;
	logic accept;

	// The result slot is free when empty or being drained this cycle.
	assign out_free = ~out_valid_q | ~out_stall;
	// Only a last byte needs the result slot; other bytes always advance.
	assign adv_s1   = valid_s1 & (~last_s1 | out_free);
	assign in_stall = valid_s1 & ~adv_s1;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Load the payload only on an accepted request; hold otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	utf8v_step u_step (
		.cur     (state_q),
		.b       (byte_s1),
		.nxt     (state_nxt),
		.verdict (verdict)
	);

	// Advance the decoder per byte; return to idle at the end of each string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateIdle;
		end else if (adv_s1) begin
			state_q <= last_s1 ? StateIdle : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			text_valid_q <= verdict;
		end
	end

	assign out_valid  = out_valid_q;
	assign text_valid = text_valid_q;

endmodule
